### design/bmce_pkg.sv
// ----------------------------------------------------------------------------
// bmce_pkg: shared types and constants of the Bezier movement curve evaluator
// Register indexes, field widths and fixed-point constants.
// ----------------------------------------------------------------------------
package bmce_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int DATE_W  = 32;
  localparam int VALUE_W = 32;
  localparam int PARAM_W = 25;
  localparam int CURV_W  = 17;
  localparam int PROT_W  = 18;

  // Signed accumulator of the shared multiply-add unit, and operand magnitude
  localparam int ACC_W = 52;
  localparam int MAG_W = 40;
  localparam int COEF_W = 20;
  localparam int XPOS_W = 18;

  localparam int ONE_Q16 = 65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_DATE  = 3'd0,
    REG_END_DATE    = 3'd1,
    REG_START_VALUE = 3'd2,
    REG_END_VALUE   = 3'd3,
    REG_CURVATURE   = 3'd4,
    REG_PROTRACTION = 3'd5
  } cfg_reg_e;

endpackage

### design/bezier_movement_curve_eval_top.sv
// ----------------------------------------------------------------------------
// bezier_movement_curve_eval_top: cubic Bezier movement curve evaluator
// Returns the curve value at a date by bisecting the curve's time polynomial.
// ----------------------------------------------------------------------------
// One item in, one item out. A date at or before start_date returns start_value
// and a date at or after end_date returns end_value; the classify state loads
// that result into the output register once it is free, then returns to idle.
// Any other date runs a bisection over the curve parameter t. The multiply-adds
// all go through one 32x32 multiplier followed by a signed add; each truncated
// multiply-add runs through operand load, low partial product, high partial
// product and accumulate. The search evaluates the time polynomial 1 to
// MAX_STEPS+1 times, and the final blend waits until the output register is
// free. The block takes one item at a time; input ready is high only while
// idle. A finished result sits in an output register, so a new item can be
// accepted while the previous result still waits to be taken. not_converged
// flags a search that used up MAX_STEPS corrections with the error still one
// tick or more. Configuration is written through a plain write port (index,
// data); the user must write it only while the block is idle, which the block
// itself does not enforce.
// ----------------------------------------------------------------------------
module bezier_movement_curve_eval_top
  import bmce_pkg::*;
#(
  parameter int T_FRAC_BITS = 24,
  parameter int MAX_STEPS   = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input item
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DATE_W-1:0]     date_i,
  // result item
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VALUE_W-1:0]    value_o,
  output logic [PARAM_W-1:0]    curve_param_o,
  output logic                  not_converged_o
);

  localparam int K_W = $clog2(MAX_STEPS + 1);
  localparam logic [PARAM_W-1:0] END_PARAM = PARAM_W'(64'(1) << T_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] ERR_LIM = ACC_W'(ONE_Q16);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_LOAD,
    S_LO,
    S_HI,
    S_ACC,
    S_COEF,
    S_CHECK
  } state_e;

  // Multiply-add operations run on the shared unit, in sequence order
  typedef enum logic [3:0] {
    OP_X1,   // inner control x1 from curvature and protraction
    OP_X2,   // inner control x2
    OP_H1,   // Horner: u*t + v
    OP_H2,   // Horner: (.)*t + w
    OP_H3,   // Horner: (.)*t
    OP_ERR,  // X*span in Q16 ticks minus relative date
    OP_T2,   // t^2
    OP_H,    // (3 - 2t) * t^2
    OP_BL    // start_value + (end_value - start_value) * h
  } op_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DATE_W-1:0]        start_date_q, end_date_q;
  logic signed [VALUE_W-1:0] start_value_q, end_value_q;
  logic [CURV_W-1:0]        curvature_q;
  logic signed [PROT_W-1:0] protraction_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_date_q  <= '0;
      end_date_q    <= '0;
      start_value_q <= '0;
      end_value_q   <= VALUE_W'(ONE_Q16);
      curvature_q   <= '0;
      protraction_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_START_DATE:  start_date_q  <= cfg_wdata_i[DATE_W-1:0];
        REG_END_DATE:    end_date_q    <= cfg_wdata_i[DATE_W-1:0];
        REG_START_VALUE: start_value_q <= cfg_wdata_i[VALUE_W-1:0];
        REG_END_VALUE:   end_value_q   <= cfg_wdata_i[VALUE_W-1:0];
        REG_CURVATURE:   curvature_q   <= cfg_wdata_i[CURV_W-1:0];
        REG_PROTRACTION: protraction_q <= cfg_wdata_i[PROT_W-1:0];
        default: ; // unknown index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state and registered outputs
  // --------------------------------------------------------------------------
  state_e                 state_q;
  op_e                    op_q;
  logic [T_FRAC_BITS-1:0] t_q;
  logic [T_FRAC_BITS-2:0] tt_q;
  logic [K_W-1:0]         k_q;
  logic                   fail_q;
  logic                   out_valid_q;
  logic [VALUE_W-1:0]     value_q;
  logic [PARAM_W-1:0]     param_q;
  logic                   nc_q;

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  logic [DATE_W-1:0]        date_q, rel_q, span_q;
  logic [CURV_W-1:0]        c_q;
  logic                     p_neg_q;
  logic [CURV_W-1:0]        p_mag_q;
  logic signed [XPOS_W-1:0] x1_q;
  logic signed [COEF_W-1:0] u_q, v_q, w_q;
  logic                     op_neg_q, op_sh16_q;
  logic [MAG_W-1:0]         op_m_q;
  logic [31:0]              op_b_q;
  logic signed [ACC_W-1:0]  op_add_q;
  logic [63:0]              prod_q, lo_q;
  logic signed [ACC_W-1:0]  acc_q;

  // --------------------------------------------------------------------------
  // Combinational datapath
  // --------------------------------------------------------------------------
  logic [31:0]              tq;
  logic signed [ACC_W-1:0]  c_s, omc_s;
  logic signed [ACC_W-1:0]  ld_a, ld_a_mag, ld_add;
  logic [31:0]              ld_b;
  logic                     ld_sh16;
  logic [31:0]              mul_a;
  logic [63:0]              mul_p;
  logic [ACC_W-1:0]         hi_sh, lo_sh, sum_r;
  logic signed [ACC_W-1:0]  acc_d;
  logic                     err_small, err_pos, out_free, out_set;
  logic                     date_le_start, date_ge_end;
  logic [PROT_W-1:0]        p_abs;
  logic [CURV_W-1:0]        c_sat, p_sat;
  logic signed [XPOS_W-1:0] x2_s;

  // t widened to Q0.32
  assign tq = 32'(t_q) << (32 - T_FRAC_BITS);

  assign c_s   = ACC_W'(c_q);
  assign omc_s = ACC_W'(ONE_Q16) - c_s;

  // Clamp curvature to one and protraction to plus/minus one
  assign c_sat = (curvature_q > CURV_W'(ONE_Q16)) ? CURV_W'(ONE_Q16) : curvature_q;
  assign p_abs = protraction_q[PROT_W-1] ? (~protraction_q + 1'b1) : protraction_q;
  assign p_sat = (p_abs > PROT_W'(ONE_Q16)) ? CURV_W'(ONE_Q16) : p_abs[CURV_W-1:0];

  assign date_le_start = (date_q <= start_date_q);
  assign date_ge_end   = (date_q >= end_date_q);

  // Operand selection for the next multiply-add
  always_comb begin
    ld_a    = '0;
    ld_b    = '0;
    ld_add  = '0;
    ld_sh16 = 1'b0;
    unique case (op_q)
      OP_X1: begin
        ld_a    = p_neg_q ? -c_s : omc_s;
        ld_b    = 32'(p_mag_q);
        ld_add  = c_s;
        ld_sh16 = 1'b1;
      end
      OP_X2: begin
        ld_a    = p_neg_q ? -omc_s : c_s;
        ld_b    = 32'(p_mag_q);
        ld_add  = omc_s;
        ld_sh16 = 1'b1;
      end
      OP_H1: begin
        ld_a   = {{(ACC_W-COEF_W-16){u_q[COEF_W-1]}}, u_q, 16'b0};
        ld_b   = tq;
        ld_add = {{(ACC_W-COEF_W-16){v_q[COEF_W-1]}}, v_q, 16'b0};
      end
      OP_H2: begin
        ld_a   = acc_q;
        ld_b   = tq;
        ld_add = {{(ACC_W-COEF_W-16){w_q[COEF_W-1]}}, w_q, 16'b0};
      end
      OP_H3: begin
        ld_a = acc_q;
        ld_b = tq;
      end
      OP_ERR: begin
        ld_a    = acc_q;
        ld_b    = span_q;
        ld_add  = -$signed({4'b0, rel_q, 16'b0});
        ld_sh16 = 1'b1;
      end
      OP_T2: begin
        ld_a = ACC_W'(tq);
        ld_b = tq;
      end
      OP_H: begin
        ld_a = (ACC_W'(3) << 32) - $signed({19'b0, tq, 1'b0});
        ld_b = acc_q[31:0];
      end
      OP_BL: begin
        ld_a   = ACC_W'(end_value_q) - ACC_W'(start_value_q);
        ld_b   = acc_q[31:0];
        ld_add = ACC_W'(start_value_q);
      end
      default: ;
    endcase
  end

  assign ld_a_mag = ld_a[ACC_W-1] ? -ld_a : ld_a;

  // Shared multiplier: low 32 bits of the magnitude, then its high part
  assign mul_a = (state_q == S_HI) ? 32'(op_m_q[MAG_W-1:32]) : op_m_q[31:0];
  assign mul_p = mul_a * op_b_q;

  // Truncated product magnitude plus the signed addend
  assign hi_sh = op_sh16_q ? {prod_q[ACC_W-17:0], 16'b0} : prod_q[ACC_W-1:0];
  assign lo_sh = op_sh16_q ? {4'b0, lo_q[63:16]} : {20'b0, lo_q[63:32]};
  assign sum_r = hi_sh + lo_sh;
  assign acc_d = op_neg_q ? (op_add_q - $signed(sum_r)) : (op_add_q + $signed(sum_r));

  assign err_small = (acc_q < ERR_LIM) && (acc_q > -ERR_LIM);
  assign err_pos   = !acc_q[ACC_W-1] && (acc_q != '0);
  assign out_free  = !out_valid_q || out_ready_i;

  // A result enters the output register: an endpoint item or the final blend
  assign out_set = out_free &&
                   (((state_q == S_CLASS) && (date_le_start || date_ge_end)) ||
                    ((state_q == S_ACC) && (op_q == OP_BL)));

  assign x2_s = acc_q[XPOS_W-1:0];

  // --------------------------------------------------------------------------
  // Datapath registers: no reset
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          date_q <= date_i;
        end
      end
      S_CLASS: begin
        rel_q   <= date_q - start_date_q;
        span_q  <= end_date_q - start_date_q;
        c_q     <= c_sat;
        p_neg_q <= protraction_q[PROT_W-1];
        p_mag_q <= p_sat;
      end
      S_LOAD: begin
        op_neg_q  <= ld_a[ACC_W-1];
        op_m_q    <= ld_a_mag[MAG_W-1:0];
        op_b_q    <= ld_b;
        op_add_q  <= ld_add;
        op_sh16_q <= ld_sh16;
      end
      S_LO: begin
        prod_q <= mul_p;
      end
      S_HI: begin
        lo_q   <= prod_q;
        prod_q <= mul_p;
      end
      S_ACC: begin
        acc_q <= acc_d;
        if (op_q == OP_X1) begin
          x1_q <= acc_d[XPOS_W-1:0];
        end
      end
      S_COEF: begin
        // u = 3x1 - 3x2 + 1, v = -6x1 + 3x2, w = 3x1, all Q16
        u_q <= COEF_W'(3 * COEF_W'(x1_q) - 3 * COEF_W'(x2_s) + COEF_W'(ONE_Q16));
        v_q <= COEF_W'(3 * COEF_W'(x2_s) - 6 * COEF_W'(x1_q));
        w_q <= COEF_W'(3 * COEF_W'(x1_q));
      end
      S_CHECK: ;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_X1;
      t_q         <= '0;
      tt_q        <= '0;
      k_q         <= '0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
      param_q     <= '0;
      nc_q        <= 1'b0;
    end else begin
      // load a new result, else drop the one just taken
      out_valid_q <= out_set || (out_valid_q && !out_ready_i);
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_CLASS;
          end
        end
        S_CLASS: begin
          priority if (date_le_start) begin
            if (out_free) begin
              value_q     <= start_value_q;
              param_q     <= '0;
              nc_q        <= 1'b0;
              state_q     <= S_IDLE;
            end
          end else if (date_ge_end) begin
            if (out_free) begin
              value_q     <= end_value_q;
              param_q     <= END_PARAM;
              nc_q        <= 1'b0;
              state_q     <= S_IDLE;
            end
          end else begin
            op_q    <= OP_X1;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: state_q <= S_LO;
        S_LO:   state_q <= S_HI;
        S_HI:   state_q <= S_ACC;
        S_ACC: begin
          unique case (op_q)
            OP_X1: begin
              op_q    <= OP_X2;
              state_q <= S_LOAD;
            end
            OP_X2: state_q <= S_COEF;
            OP_H1: begin
              op_q    <= OP_H2;
              state_q <= S_LOAD;
            end
            OP_H2: begin
              op_q    <= OP_H3;
              state_q <= S_LOAD;
            end
            OP_H3: begin
              op_q    <= OP_ERR;
              state_q <= S_LOAD;
            end
            OP_ERR: state_q <= S_CHECK;
            OP_T2: begin
              op_q    <= OP_H;
              state_q <= S_LOAD;
            end
            OP_H: begin
              op_q    <= OP_BL;
              state_q <= S_LOAD;
            end
            OP_BL: begin
              // hold here until the output register is free
              if (out_free) begin
                value_q     <= acc_d[VALUE_W-1:0];
                param_q     <= PARAM_W'(t_q);
                nc_q        <= fail_q;
                state_q     <= S_IDLE;
              end
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_COEF: begin
          t_q     <= {1'b1, {(T_FRAC_BITS-1){1'b0}}};
          tt_q    <= {1'b1, {(T_FRAC_BITS-2){1'b0}}};
          k_q     <= '0;
          op_q    <= OP_H1;
          state_q <= S_LOAD;
        end
        S_CHECK: begin
          if (err_small || (k_q >= K_W'(MAX_STEPS))) begin
            fail_q  <= !err_small;
            op_q    <= OP_T2;
            state_q <= S_LOAD;
          end else begin
            // positive error: the curve is late, step t back
            if (err_pos) begin
              t_q <= t_q - T_FRAC_BITS'(tt_q);
            end else begin
              t_q <= t_q + T_FRAC_BITS'(tt_q);
            end
            tt_q    <= tt_q >> 1;
            k_q     <= k_q + 1'b1;
            op_q    <= OP_H1;
            state_q <= S_LOAD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign value_o         = value_q;
  assign curve_param_o   = param_q;
  assign not_converged_o = nc_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CLASS))
    else $error("accepted item did not start classification");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (k_q <= K_W'(MAX_STEPS)))
    else $error("correction count beyond step limit");

  a_t_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (t_q != '0))
    else $error("curve parameter left the open unit interval");

  a_blend_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC && op_q == OP_BL && out_valid_q && !out_ready_i)
      |=> (state_q == S_ACC && out_valid_q))
    else $error("result overwrote an item still waiting at the output");

endmodule
